// ===== rtl/trle_pkg.sv =====
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants for the TGA run-length scanline decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_WIDTH      = 2'd1;

  localparam int unsigned CFG_DATA_BITS   = 16;
  localparam int unsigned MAX_PIXEL_BYTES = 4;
  localparam int unsigned WIDTH_BITS      = 16;

  localparam logic [2:0] BPP_RESET   = 3'd4;
  localparam logic [2:0] BPP_MAX     = 3'(MAX_PIXEL_BYTES);
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(1);

  // Packet header fields
  localparam logic [7:0] HDR_RUN_MASK   = 8'h80;
  localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;

  typedef struct packed {
    logic                  expect_header;
    logic                  run_packet;
    logic                  drop_rest;
    logic [7:0]            packet_left;
    logic [1:0]            byte_position;
    logic [23:0]           pixel_gather;
    logic [WIDTH_BITS-1:0] column;
  } trle_state_t;

  // Parser state after reset: waiting for a packet header at column zero
  localparam trle_state_t STATE_RESET = '{
    expect_header: 1'b1,
    run_packet:    1'b0,
    drop_rest:     1'b0,
    packet_left:   8'd0,
    byte_position: 2'd0,
    pixel_gather:  24'h0,
    column:        {WIDTH_BITS{1'b0}}
  };

  typedef struct packed {
    logic        valid;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        line_end;
  } trle_result_t;

endpackage

// ===== rtl/tga_rle_scanline_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_rle_scanline_decoder
// Run-length scanline decoder for TGA image streams, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------------
//   in      | sink      | in_valid/in_stall | in_data_byte[7:0]
//   out     | source    | out_valid/out_stall | out_pixel_value[31:0],
//           |           |                   | out_repeat_count[7:0], out_line_end
//   cfg     | sink      | cfg_we            | cfg_index[1:0], cfg_data[15:0]
//
// One byte is accepted every cycle unless the input stalls; its result (if
// any) appears in the output register on the next cycle.
// The parse state and the result register are the only timing stages; the
// path between them is one 17-bit subtract/compare plus selection.
// A new byte is taken while the result register drains; the input stalls
// only when a result is held and the consumer stalls.
// Synchronous active-low reset returns the parser to header wait with
// column zero, bytes per pixel 4 and line width 1.
// ----------------------------------------------------------------------------
module tga_rle_scanline_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_data_byte,
  // result stream
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [31:0]                          out_pixel_value,
  output logic [7:0]                           out_repeat_count,
  output logic                                 out_line_end,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [trle_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [trle_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic [2:0]                      bpp_r;
  logic [trle_pkg::WIDTH_BITS-1:0] width_r;
  trle_pkg::trle_state_t           st_r;
  trle_pkg::trle_state_t           st_nxt;
  trle_pkg::trle_result_t          res;
  logic                            out_valid_r;
  logic [31:0]                     pixel_r;
  logic [7:0]                      repeat_r;
  logic                            line_end_r;
  logic                            in_accept;

  // Stall only while a held result cannot leave this cycle
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Configuration registers; writes to unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= trle_pkg::BPP_RESET;
      width_r <= trle_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        trle_pkg::CFG_BYTES_PER_PIXEL: bpp_r   <= cfg_data[2:0];
        trle_pkg::CFG_LINE_WIDTH:      width_r <= cfg_data[trle_pkg::WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  trle_step u_step (
    .cur             (st_r),
    .data_byte       (in_data_byte),
    .bytes_per_pixel (bpp_r),
    .line_width      (width_r),
    .nxt             (st_nxt),
    .res             (res)
  );

  // Parse state: advance only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= trle_pkg::STATE_RESET;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  // Result register: load on a new result, clear once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (in_accept && res.valid) begin
      pixel_r    <= res.pixel_value;
      repeat_r   <= res.repeat_count;
      line_end_r <= res.line_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = pixel_r;
  assign out_repeat_count = repeat_r;
  assign out_line_end     = line_end_r;

  // A header byte never yields a result
  a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && st_r.expect_header) |=> !out_valid_r)
    else $error("result produced for a header byte");

  // An open packet always has pixels left
  a_packet_open: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.expect_header |-> (st_r.packet_left != 8'd0))
    else $error("open packet with no pixels left");

  // Dropping only happens inside raw packets
  a_drop_raw: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.drop_rest |-> !st_r.run_packet)
    else $error("drop mode inside a run packet");

  // A line-ending result returns the column to zero
  a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && res.valid && res.line_end) |=> (st_r.column == '0))
    else $error("column not cleared at line end");

  // Results carry a repeat count of 1 to 128
  a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_repeat_count != 8'd0 && out_repeat_count <= 8'd128))
    else $error("repeat count out of range");

endmodule

// ===== rtl/trle_step.sv =====
// ----------------------------------------------------------------------------
// trle_step
// Next-state and result logic for one compressed byte.
// ----------------------------------------------------------------------------
module trle_step (
  input  trle_pkg::trle_state_t              cur,
  input  logic [7:0]                         data_byte,
  input  logic [2:0]                         bytes_per_pixel,
  input  logic [trle_pkg::WIDTH_BITS-1:0]    line_width,
  output trle_pkg::trle_state_t              nxt,
  output trle_pkg::trle_result_t             res
);

  logic [2:0]                      bpp_eff;
  logic [trle_pkg::WIDTH_BITS:0]   width_eff;
  logic [trle_pkg::WIDTH_BITS:0]   col_ext;
  logic [trle_pkg::WIDTH_BITS:0]   rem;
  logic [4:0]                      shift;
  logic [31:0]                     placed;
  logic [31:0]                     pix;
  logic [7:0]                      rep;
  logic [7:0]                      left_dec;
  logic                            pixel_done;
  logic                            end_run;
  logic                            end_raw;

  always_comb begin
    bpp_eff = bytes_per_pixel;
    if (bpp_eff == 3'd0) begin
      bpp_eff = 3'd1;
    end
    if (bpp_eff > trle_pkg::BPP_MAX) begin
      bpp_eff = trle_pkg::BPP_MAX;
    end
    width_eff = (line_width == '0) ? {1'b1, {trle_pkg::WIDTH_BITS{1'b0}}}
                                   : {1'b0, line_width};
    col_ext  = {1'b0, cur.column};
    rem      = (col_ext < width_eff) ? (width_eff - col_ext)
                                     : {{trle_pkg::WIDTH_BITS{1'b0}}, 1'b1};
    shift    = {cur.byte_position, 3'b000};
    placed   = {24'h0, data_byte} << shift;
    pix      = {8'h0, cur.pixel_gather} | placed;
    pixel_done = ({1'b0, cur.byte_position} + 3'd1) >= bpp_eff;
    // rem <= packet_left <= 128 means rem fits in eight bits
    rep      = ({9'b0, cur.packet_left} < rem) ? cur.packet_left : rem[7:0];
    end_run  = ({9'b0, rep} == rem);
    end_raw  = (rem == {{trle_pkg::WIDTH_BITS{1'b0}}, 1'b1});
    left_dec = (cur.packet_left != 8'd0) ? (cur.packet_left - 8'd1) : 8'd0;

    nxt = cur;
    res = '0;
    res.pixel_value = pix;

    if (cur.expect_header) begin
      nxt.run_packet    = (data_byte & trle_pkg::HDR_RUN_MASK) != 8'd0;
      nxt.packet_left   = (data_byte & trle_pkg::HDR_COUNT_MASK) + 8'd1;
      nxt.expect_header = 1'b0;
      nxt.byte_position = 2'd0;
      nxt.pixel_gather  = 24'h0;
      nxt.drop_rest     = 1'b0;
    end else if (!pixel_done) begin
      nxt.pixel_gather  = pix[23:0];
      nxt.byte_position = cur.byte_position + 2'd1;
    end else begin
      nxt.byte_position = 2'd0;
      nxt.pixel_gather  = 24'h0;
      if (cur.run_packet) begin
        nxt.column        = end_run ? '0 : (cur.column + {8'h0, rep});
        nxt.packet_left   = 8'd0;
        nxt.expect_header = 1'b1;
        res.valid         = 1'b1;
        res.repeat_count  = rep;
        res.line_end      = end_run;
      end else begin
        nxt.packet_left = left_dec;
        if (cur.drop_rest) begin
          // Drop pixels past the line end
          if (left_dec == 8'd0) begin
            nxt.expect_header = 1'b1;
            nxt.drop_rest     = 1'b0;
          end
        end else begin
          if (end_raw) begin
            nxt.column    = '0;
            nxt.drop_rest = 1'b1;
          end else begin
            nxt.column    = cur.column + 16'd1;
          end
          if (left_dec == 8'd0) begin
            nxt.expect_header = 1'b1;
            nxt.drop_rest     = 1'b0;
          end
          res.valid        = 1'b1;
          res.repeat_count = 8'd1;
          res.line_end     = end_raw;
        end
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TGA run-length scanline decoder: a directed
// pass over header, clipping and drop corners, then randomized packet streams
// under several pixel sizes and line widths with bursty input and a stalling
// consumer. A scoreboard predicts every pixel run and compares in order.
// ----------------------------------------------------------------------------
module tb;

  // Register indexes past the end of the map; writes to them must be ignored
  localparam logic [trle_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [trle_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  // Cycles to let pass after the last run before touching a register
  localparam int IDLE_TAIL = 4;

  typedef struct {
    logic [31:0] pixel;
    logic [7:0]  reps;
    logic        line_end;
  } pixel_run_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the decoder's parse state and queues expected runs
  // --------------------------------------------------------------------------
  class pixel_run_scoreboard;
    logic [2:0]                      bpp_reg;
    logic [trle_pkg::WIDTH_BITS-1:0] width_reg;
    bit                              expect_header;
    bit                              run_packet;
    bit                              drop_rest;
    logic [7:0]                      packet_left;
    logic [1:0]                      byte_pos;
    logic [23:0]                     gather;
    logic [trle_pkg::WIDTH_BITS-1:0] column;
    pixel_run_t                      run_queue[$];
    int                              mismatch_count;

    function new();
      bpp_reg        = trle_pkg::BPP_RESET;
      width_reg      = trle_pkg::WIDTH_RESET;
      expect_header  = 1'b1;
      run_packet     = 1'b0;
      drop_rest      = 1'b0;
      packet_left    = '0;
      byte_pos       = '0;
      gather         = '0;
      column         = '0;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [trle_pkg::CFG_INDEX_BITS-1:0] idx,
                               logic [trle_pkg::CFG_DATA_BITS-1:0] data);
      if (idx == trle_pkg::CFG_BYTES_PER_PIXEL) bpp_reg = data[2:0];
      else if (idx == trle_pkg::CFG_LINE_WIDTH) width_reg = data[trle_pkg::WIDTH_BITS-1:0];
    endfunction

    // zero means one byte, anything past the maximum saturates
    function logic [2:0] pixel_bytes();
      logic [2:0] nb;
      nb = bpp_reg;
      if (nb == 3'd0) nb = 3'd1;
      if (nb > trle_pkg::BPP_MAX) nb = trle_pkg::BPP_MAX;
      return nb;
    endfunction

    // zero width stands for a full 2^WIDTH_BITS line
    function logic [trle_pkg::WIDTH_BITS:0] line_span();
      logic [trle_pkg::WIDTH_BITS:0] w;
      w = {1'b0, width_reg};
      if (w == '0) w = {1'b1, {trle_pkg::WIDTH_BITS{1'b0}}};
      return w;
    endfunction

    function void queue_run(logic [31:0] pix, logic [7:0] reps, logic done);
      pixel_run_t r;
      r.pixel    = pix;
      r.reps     = reps;
      r.line_end = done;
      run_queue.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [trle_pkg::WIDTH_BITS:0] w;
      logic [trle_pkg::WIDTH_BITS:0] rem;
      logic [trle_pkg::WIDTH_BITS:0] span;
      logic [31:0]                   pix;
      logic                          done;
      w = line_span();
      if (expect_header) begin
        run_packet    = (b & trle_pkg::HDR_RUN_MASK) != 8'h00;
        packet_left   = (b & trle_pkg::HDR_COUNT_MASK) + 8'd1;
        expect_header = 1'b0;
        byte_pos      = '0;
        gather        = '0;
        drop_rest     = 1'b0;
        return;
      end
      // gather bytes until the pixel is complete, first byte lowest
      if ({1'b0, byte_pos} + 3'd1 < pixel_bytes()) begin
        gather   = 24'((32'(gather) | (32'(b) << (8 * byte_pos))));
        byte_pos = byte_pos + 2'd1;
        return;
      end
      pix      = 32'(gather) | (32'(b) << (8 * byte_pos));
      byte_pos = '0;
      gather   = '0;
      rem = ({1'b0, column} < w) ? (w - {1'b0, column})
                                 : (trle_pkg::WIDTH_BITS+1)'(1);
      if (run_packet) begin
        span          = ((trle_pkg::WIDTH_BITS+1)'(packet_left) < rem)
                        ? (trle_pkg::WIDTH_BITS+1)'(packet_left) : rem;
        done          = (span == rem);
        column        = done ? '0 : column + span[trle_pkg::WIDTH_BITS-1:0];
        packet_left   = '0;
        expect_header = 1'b1;
        queue_run(pix, span[7:0], done);
        return;
      end
      if (packet_left != 8'd0) packet_left = packet_left - 8'd1;
      if (drop_rest) begin
        if (packet_left == 8'd0) begin
          expect_header = 1'b1;
          drop_rest     = 1'b0;
        end
        return;
      end
      done = (rem == (trle_pkg::WIDTH_BITS+1)'(1));
      if (done) begin
        column    = '0;
        drop_rest = 1'b1;
      end else begin
        column = column + 1'b1;
      end
      if (packet_left == 8'd0) begin
        expect_header = 1'b1;
        drop_rest     = 1'b0;
      end
      queue_run(pix, 8'd1, done);
    endfunction

    function int pending();
      return run_queue.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_run(logic [31:0] pix, logic [7:0] reps, logic done);
      pixel_run_t want;
      if (run_queue.size() == 0) begin
        report($sformatf("run with nothing pending: pixel %h repeat %0d line_end %b",
                         pix, reps, done));
        return;
      end
      want = run_queue.pop_front();
      if (pix !== want.pixel)
        report($sformatf("pixel_value %h, predicted %h", pix, want.pixel));
      if (reps !== want.reps)
        report($sformatf("repeat_count %0d, predicted %0d", reps, want.reps));
      if (done !== want.line_end)
        report($sformatf("line_end %b, predicted %b", done, want.line_end));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic [7:0]                          in_data_byte;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [31:0]                         out_pixel_value;
  logic [7:0]                          out_repeat_count;
  logic                                out_line_end;
  logic                                cfg_we;
  logic [trle_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [trle_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  pixel_run_scoreboard sb;
  int                  burst_left = 0;
  int                  items_sent = 0;
  stall_mode_t         stall_mode = STALL_NONE;
  int                  stall_left = 0;

  tga_rle_scanline_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_value  (out_pixel_value),
    .out_repeat_count (out_repeat_count),
    .out_line_end     (out_line_end),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Consumer back-pressure: switch between four stall styles at random
  // intervals so stalls land on every phase of the parse, with quiet
  // stretches in between.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 99) < 75);
      default:      out_stall <= ((stall_left % 7) < 3);
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitors: values are read at the edge before any update of this step.
  // Feed every accepted byte to the predictor, check every accepted run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_byte(in_data_byte);
    if (rst_n && out_valid && !out_stall)
      sb.check_run(out_pixel_value, out_repeat_count, out_line_end);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Write one register; the block must be idle. Mirror it in the scoreboard
  // at the edge where the write lands.
  task automatic write_reg(input logic [trle_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [trle_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one byte and hold it until taken. Open a new burst when the old
  // one is used up, idling the input for a random gap first.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Drop valid and wait until every predicted run has drained, then wait
  // out the IDLE_TAIL idle stretch.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
    burst_left = 0;
  endtask

  // Bias pixel bytes toward all-zeros and all-ones
  function automatic logic [7:0] pixel_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // One well-formed packet: header, then one pixel (run) or count pixels
  // (raw). Mostly short packets, now and then a long one.
  task automatic send_packet();
    bit is_run;
    int sel;
    int count;
    int nbytes;
    is_run = $urandom_range(0, 1);
    sel    = $urandom_range(0, 9);
    if (sel < 7) count = $urandom_range(1, 8);
    else if (sel < 9) count = $urandom_range(9, 40);
    else count = $urandom_range(100, 128);
    push_byte((is_run ? trle_pkg::HDR_RUN_MASK : 8'h00)
              | (8'(count - 1) & trle_pkg::HDR_COUNT_MASK));
    nbytes = (is_run ? 1 : count) * int'(sb.pixel_bytes());
    repeat (nbytes) push_byte(pixel_byte());
  endtask

  // One configuration phase of random traffic. Mostly packets; the rest is
  // loose bytes that knock the stream out of packet alignment.
  task automatic run_phase(input logic [2:0] bpp, input logic [15:0] width,
                           input int quota, input bit hold_midway);
    int start;
    settle();
    write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, (trle_pkg::CFG_DATA_BITS)'(bpp));
    write_reg(trle_pkg::CFG_LINE_WIDTH, width);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
    start = items_sent;
    while (items_sent - start < quota) begin
      // hold the sender once until the output side is fully drained
      if (hold_midway && (items_sent - start >= quota / 2)) begin
        hold_midway = 1'b0;
        settle();
      end
      if ($urandom_range(0, 99) < 85) send_packet();
      else repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    cfg_we       = 1'b0;
    cfg_index    = trle_pkg::CFG_BYTES_PER_PIXEL;
    cfg_data     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings (4-byte pixels, one-pixel line): a 128-long run clips to 1
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h5A);

    // 1-byte pixels, 3-wide line: raw of 5 emits 3 then drops the tail
    settle();
    write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 16'd1);
    write_reg(trle_pkg::CFG_LINE_WIDTH, 16'd3);
    push_byte(8'h04);
    push_byte(8'h01);
    push_byte(8'h80);
    push_byte(8'h7F);
    push_byte(8'hFE);
    push_byte(8'h55);

    // Zero bytes per pixel acts as one, zero width as a full 65536 line
    settle();
    write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 16'd0);
    write_reg(trle_pkg::CFG_LINE_WIDTH, 16'd0);
    push_byte(8'h80);
    push_byte(8'h81);
    push_byte(8'h00);
    push_byte(8'h7E);

    // Shrink the pixel size in mid pixel: it completes on the next byte
    settle();
    write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 16'd4);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'hA5A5);
    push_byte(8'h01);
    push_byte(8'h11);
    push_byte(8'h22);
    settle();
    write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 16'd2);
    push_byte(8'h33);
    push_byte(8'h44);
    push_byte(8'h55);

    // Widest line, then shrink it below the column: next run is 1 and ends the line
    settle();
    write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 16'd1);
    write_reg(trle_pkg::CFG_LINE_WIDTH, 16'hFFFF);
    push_byte(8'h85);
    push_byte(8'hC3);
    settle();
    write_reg(trle_pkg::CFG_LINE_WIDTH, 16'd5);
    push_byte(8'h83);
    push_byte(8'h3C);

    // Random traffic across pixel sizes and widths, extremes included
    run_phase(3'd1, 16'd1,     160, 1'b0);
    run_phase(3'd2, 16'd2,     160, 1'b1);
    run_phase(3'd3, 16'd7,     160, 1'b0);
    run_phase(3'd4, 16'd64,    160, 1'b0);
    run_phase(3'd5, 16'd17,    160, 1'b0);
    run_phase(3'd1, 16'hFFFF,  160, 1'b0);
    run_phase(3'd0, 16'd3,     160, 1'b0);
    run_phase(3'd7, 16'd200,   160, 1'b0);
    run_phase(3'd2, 16'd0,     150, 1'b0);
    run_phase(3'($urandom_range(0, 7)), 16'($urandom_range(1, 32)),  160, 1'b0);
    run_phase(3'($urandom_range(1, 4)), 16'($urandom_range(1, 300)), 160, 1'b0);

    // Drain everything, then account for runs that never showed up
    settle();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted runs never arrived", sb.pending()));
    if (sb.mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
